// ===== hw/rtl/rtc_calendar_register_port_macros.svh =====
// ----------------------------------------------------------------------------
// RTC register port assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef RTC_CALENDAR_REGISTER_PORT_MACROS_SVH
`define RTC_CALENDAR_REGISTER_PORT_MACROS_SVH

// same-cycle implication
`define RTCP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtcp assertion failed");

// next-cycle implication
`define RTCP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtcp assertion failed");

`endif

// ===== hw/rtl/rtcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC register port package
// Op codes, register map, calendar types and BCD helpers.
// ----------------------------------------------------------------------------
package rtcp_pkg;

   localparam int NUM_REGS_DEF = 19;
   localparam int TIME_REGS    = 7;
   localparam int OP_W         = 3;
   localparam int DATA_W       = 8;

   typedef enum logic [OP_W-1:0] {
      OP_SET_ADDR    = 3'd0,
      OP_SET_DATA    = 3'd1,
      OP_COMMAND     = 3'd2,
      OP_READ_LATCH  = 3'd3,
      OP_READ_STATUS = 3'd4,
      OP_TICK        = 3'd5
   } op_type;

   localparam logic [DATA_W-1:0] CMD_READ  = 8'd1;
   localparam logic [DATA_W-1:0] CMD_WRITE = 8'd2;

   // register map of the time block
   localparam int REG_SEC   = 0;
   localparam int REG_MIN   = 1;
   localparam int REG_HOUR  = 2;
   localparam int REG_WDAY  = 3;
   localparam int REG_DATE  = 4;
   localparam int REG_MONTH = 5;
   localparam int REG_YEAR  = 6;

   localparam logic [DATA_W-1:0] HOUR_12H_MASK = 8'h40;
   localparam logic [DATA_W-1:0] HOUR_PM_MASK  = 8'h20;
   localparam logic [DATA_W-1:0] CENTURY_MASK  = 8'h80;
   localparam int HOUR_12H_BIT = 6;
   localparam int HOUR_PM_BIT  = 5;
   localparam int CENTURY_BIT  = 7;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
      logic [2:0] wday;
      logic [4:0] date;
      logic [3:0] month;
      logic [6:0] year;
      logic       century;
   } cal_time_type;

   typedef struct packed {
      logic         tick;
      logic         load;
      cal_time_type value;
   } cal_ctrl_type;

   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
   } beat_type;

   // binary 0..99 to packed BCD
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] rem;
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (v >= 7'(10 * k)) begin
            tens = 4'(k);
         end
      end
      rem = v - 7'(10 * int'(tens));
      return {tens, rem[3:0]};
   endfunction

   // 10*hi + lo, no range check
   function automatic logic [7:0] bcd_value(input logic [3:0] hi, input logic [3:0] lo);
      return 8'({hi, 3'b000}) + 8'({hi, 1'b0}) + 8'(lo);
   endfunction

   // leap year on every year divisible by four
   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic [6:0] year);
      logic [4:0] d;
      case (month)
         4'd2: begin
            d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            d = 5'd30;
         end
         default: begin
            d = 5'd31;
         end
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rtcp_calendar.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC running calendar
// Binary time of day and date; advances one second per tick, loads on rebuild.
// ----------------------------------------------------------------------------
`include "rtc_calendar_register_port_macros.svh"

module rtcp_calendar (
   input  logic                   clock,
   input  logic                   reset,
   input  rtcp_pkg::cal_ctrl_type ctrl,
   output rtcp_pkg::cal_time_type now
);
   import rtcp_pkg::*;

   // 00:00:00, weekday 1, 1 Jan year 00, century clear
   localparam cal_time_type CAL_RESET = '{sec: 6'd0, min: 6'd0, hour: 5'd0,
                                          wday: 3'd1, date: 5'd1, month: 4'd1,
                                          year: 7'd0, century: 1'b0};

   cal_time_type cal_ff;
   cal_time_type cal_in;
   logic         time_ok;
   logic         date_ok;

   always_comb begin
      cal_in = cal_ff;
      if (ctrl.load) begin
         cal_in = ctrl.value;
      end else if (ctrl.tick) begin
         if (cal_ff.sec < 6'd59) begin
            cal_in.sec = cal_ff.sec + 6'd1;
         end else begin
            cal_in.sec = 6'd0;
            if (cal_ff.min < 6'd59) begin
               cal_in.min = cal_ff.min + 6'd1;
            end else begin
               cal_in.min = 6'd0;
               if (cal_ff.hour < 5'd23) begin
                  cal_in.hour = cal_ff.hour + 5'd1;
               end else begin
                  cal_in.hour = 5'd0;
                  // weekday 0 or 7 restarts at 1
                  cal_in.wday = (cal_ff.wday >= 3'd1 && cal_ff.wday < 3'd7) ?
                                cal_ff.wday + 3'd1 : 3'd1;
                  if (cal_ff.date < days_in_month(cal_ff.month, cal_ff.year)) begin
                     cal_in.date = cal_ff.date + 5'd1;
                  end else begin
                     cal_in.date = 5'd1;
                     if (cal_ff.month < 4'd12) begin
                        cal_in.month = cal_ff.month + 4'd1;
                     end else begin
                        cal_in.month = 4'd1;
                        if (cal_ff.year < 7'd99) begin
                           cal_in.year = cal_ff.year + 7'd1;
                        end else begin
                           cal_in.year    = 7'd0;
                           cal_in.century = ~cal_ff.century;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= CAL_RESET;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign now = cal_ff;

   assign time_ok = (cal_ff.sec <= 6'd59) && (cal_ff.min <= 6'd59) && (cal_ff.hour <= 5'd23);
   assign date_ok = (cal_ff.date >= 5'd1) && (cal_ff.month >= 4'd1) &&
                    (cal_ff.month <= 4'd12) && (cal_ff.year <= 7'd99);

   `RTCP_ASSERT_IMP(a_cal_time_range, clock, reset, 1'b1, time_ok)
   `RTCP_ASSERT_IMP(a_cal_date_range, clock, reset, 1'b1, date_ok)

endmodule
`default_nettype wire

// ===== hw/rtl/rtcp_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC register file and command decoder
// Address pointer, data latch, BCD snapshot and rebuild of the running time.
// ----------------------------------------------------------------------------
`include "rtc_calendar_register_port_macros.svh"

module rtcp_regfile #(
   parameter int NUM_REGS = rtcp_pkg::NUM_REGS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rtcp_pkg::beat_type                 beat,
   input  rtcp_pkg::cal_time_type             now,
   output rtcp_pkg::cal_ctrl_type             cal_ctrl,
   output logic [rtcp_pkg::DATA_W-1:0]        data_latch
);
   import rtcp_pkg::*;

   localparam int                IDX_W  = $clog2(NUM_REGS);
   localparam logic [DATA_W-1:0] NREG_A = DATA_W'(NUM_REGS);
   localparam logic [DATA_W-1:0] TREG_A = DATA_W'(TIME_REGS);

   logic [DATA_W-1:0] rf_ff [NUM_REGS];
   logic [DATA_W-1:0] rf_in [NUM_REGS];
   logic [DATA_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] latch_ff, latch_in;

   logic [DATA_W-1:0] snap    [TIME_REGS];
   logic [DATA_W-1:0] wr_regs [TIME_REGS];
   logic [IDX_W-1:0]  idx;
   logic              in_range;
   logic              pm;
   logic [4:0]        h12;
   logic [5:0]        h6;
   logic [7:0]        v_sec, v_min, v_date, v_month, v_year;
   cal_time_type      rebuilt;
   logic              cmd_go;

   // BCD snapshot of the running time
   always_comb begin
      pm  = (now.hour >= 5'd12);
      h12 = pm ? now.hour - 5'd12 : now.hour;
      if (h12 == 5'd0) begin
         h12 = 5'd12;
      end
      snap[REG_SEC] = to_bcd({1'b0, now.sec});
      snap[REG_MIN] = to_bcd({1'b0, now.min});
      if (rf_ff[REG_HOUR][HOUR_12H_BIT]) begin
         snap[REG_HOUR] = HOUR_12H_MASK | (pm ? HOUR_PM_MASK : 8'h00) |
                          to_bcd({2'b00, h12});
      end else begin
         snap[REG_HOUR] = to_bcd({2'b00, now.hour});
      end
      snap[REG_WDAY]  = {5'b00000, now.wday};
      snap[REG_DATE]  = to_bcd({2'b00, now.date});
      snap[REG_MONTH] = (now.century ? CENTURY_MASK : 8'h00) | to_bcd({3'b000, now.month});
      snap[REG_YEAR]  = to_bcd(now.year);
   end

   // time block as it stands after a write; rebuild decodes from it
   always_comb begin
      for (int k = 0; k < TIME_REGS; k++) begin
         wr_regs[k] = (addr_ff == DATA_W'(k)) ? latch_ff : snap[k];
      end
      v_sec   = bcd_value(wr_regs[REG_SEC][7:4], wr_regs[REG_SEC][3:0]);
      v_min   = bcd_value(wr_regs[REG_MIN][7:4], wr_regs[REG_MIN][3:0]);
      v_date  = bcd_value({2'b00, wr_regs[REG_DATE][5:4]}, wr_regs[REG_DATE][3:0]);
      v_month = bcd_value({3'b000, wr_regs[REG_MONTH][4]}, wr_regs[REG_MONTH][3:0]);
      v_year  = bcd_value(wr_regs[REG_YEAR][7:4], wr_regs[REG_YEAR][3:0]);
      if (wr_regs[REG_HOUR][HOUR_12H_BIT]) begin
         // 12 AM is hour 0, 12 PM is hour 12
         h6 = (wr_regs[REG_HOUR][4] ? 6'd10 : 6'd0) + {2'b00, wr_regs[REG_HOUR][3:0]};
         if (h6 == 6'd12) begin
            h6 = 6'd0;
         end
         if (wr_regs[REG_HOUR][HOUR_PM_BIT]) begin
            h6 = h6 + 6'd12;
         end
      end else begin
         h6 = 6'(bcd_value({2'b00, wr_regs[REG_HOUR][5:4]}, wr_regs[REG_HOUR][3:0]));
      end
      rebuilt.sec     = (v_sec > 8'd59) ? 6'd59 : v_sec[5:0];
      rebuilt.min     = (v_min > 8'd59) ? 6'd59 : v_min[5:0];
      rebuilt.hour    = (h6 > 6'd23) ? 5'd23 : h6[4:0];
      rebuilt.wday    = wr_regs[REG_WDAY][2:0];
      rebuilt.date    = (v_date < 8'd1) ? 5'd1 : ((v_date > 8'd31) ? 5'd31 : v_date[4:0]);
      rebuilt.month   = (v_month < 8'd1) ? 4'd1 :
                        ((v_month > 8'd12) ? 4'd12 : v_month[3:0]);
      rebuilt.year    = (v_year > 8'd99) ? 7'd99 : v_year[6:0];
      rebuilt.century = wr_regs[REG_MONTH][CENTURY_BIT];
   end

   // command decode
   always_comb begin
      rf_in          = rf_ff;
      addr_in        = addr_ff;
      latch_in       = latch_ff;
      idx            = addr_ff[IDX_W-1:0];
      in_range       = (addr_ff < NREG_A);
      cmd_go         = beat.valid && (beat.op == OP_COMMAND);
      cal_ctrl.tick  = beat.valid && (beat.op == OP_TICK);
      cal_ctrl.load  = 1'b0;
      cal_ctrl.value = rebuilt;
      if (beat.valid) begin
         case (beat.op)
            OP_SET_ADDR: begin
               addr_in = beat.value;
            end
            OP_SET_DATA: begin
               latch_in = beat.value;
            end
            OP_COMMAND: begin
               if (beat.value == CMD_READ) begin
                  if (addr_ff == '0) begin
                     for (int k = 0; k < TIME_REGS; k++) begin
                        rf_in[k] = snap[k];
                     end
                     latch_in = snap[REG_SEC];
                  end else begin
                     latch_in = in_range ? rf_ff[idx] : '0;
                  end
               end else if (beat.value == CMD_WRITE) begin
                  if (addr_ff < TREG_A) begin
                     for (int k = 0; k < TIME_REGS; k++) begin
                        rf_in[k] = wr_regs[k];
                     end
                     cal_ctrl.load = 1'b1;
                  end else if (in_range) begin
                     rf_in[idx] = latch_ff;
                  end
               end
               addr_in = ((addr_ff + 8'd1) == NREG_A) ? '0 : addr_ff + 8'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            rf_ff[k] <= '0;
         end
         addr_ff  <= '0;
         latch_ff <= '0;
      end else begin
         rf_ff    <= rf_in;
         addr_ff  <= addr_in;
         latch_ff <= latch_in;
      end
   end

   assign data_latch = latch_ff;

   // pointer steps by one after every command, wrapping at the top of the map
   `RTCP_ASSERT_NXT(a_rf_ptr_step, clock, reset, cmd_go, addr_ff == $past(addr_ff) + 8'd1 || addr_ff == '0)

endmodule
`default_nettype wire

// ===== hw/rtl/rtc_calendar_register_port.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC calendar register port
// Clock-calendar chip behind an address / data latch / command register port.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_op / req_value with start high; the beat is
//    taken at any rising edge where start is high and busy is low. busy is
//    held low, so one beat can be taken every cycle.
//  - Response channel: every request beat produces exactly one response beat.
//    rsp_strobe is high for one cycle with rsp_read_data valid; the data is
//    the data latch for a read-latch op and zero for everything else.
//  - Response path: a taken beat passes the input register and then the
//    result register, from which its response is shown.
//  - Throughput: one beat per cycle; all decode, BCD snapshot, rebuild and
//    calendar step fit in one pass between the two registers.
//  - Reset (synchronous, active high): register file, pointer and latch
//    clear; running time goes to 00:00:00, weekday 1, 1 Jan year 00.
//  - The receiver cannot stall; a response beat is simply gone after its
//    cycle.
// ----------------------------------------------------------------------------
`include "rtc_calendar_register_port_macros.svh"

module rtc_calendar_register_port #(
   parameter int NUM_REGS = rtcp_pkg::NUM_REGS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rtcp_pkg::OP_W-1:0]     req_op,
   input  logic [rtcp_pkg::DATA_W-1:0]   req_value,
   output logic                          rsp_strobe,
   output logic [rtcp_pkg::DATA_W-1:0]   rsp_read_data
);
   import rtcp_pkg::*;

   beat_type          beat_ff, beat_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0] data_latch;
   cal_ctrl_type      cal_ctrl;
   cal_time_type      now;

   // never back-pressures the requester
   assign busy = 1'b0;

   // input register
   always_comb begin
      beat_in.valid = start && !busy;
      beat_in.op    = req_op;
      beat_in.value = req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   rtcp_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat_ff),
      .now        (now),
      .cal_ctrl   (cal_ctrl),
      .data_latch (data_latch)
   );

   rtcp_calendar u_calendar (
      .clock (clock),
      .reset (reset),
      .ctrl  (cal_ctrl),
      .now   (now)
   );

   // result register; data is zero whenever no read-latch beat completes
   always_comb begin
      rsp_strobe_in = beat_ff.valid;
      rsp_data_in   = (beat_ff.valid && beat_ff.op == OP_READ_LATCH) ? data_latch : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         rsp_data_ff   <= '0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_data_ff;

   `RTCP_ASSERT_NXT(a_top_rsp_per_beat, clock, reset, beat_ff.valid, rsp_strobe)
   `RTCP_ASSERT_IMP(a_top_idle_data_zero, clock, reset, !rsp_strobe, rsp_read_data == '0)
   `RTCP_ASSERT_NXT(a_top_read_latch, clock, reset, beat_ff.valid && beat_ff.op == OP_READ_LATCH, rsp_read_data == $past(data_latch))

endmodule
`default_nettype wire
